FILE: rtl/utf8_stream_decoder_core_macros.svh
// Assertion macros shared by the UTF-8 stream decoder RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef UTF8_STREAM_DECODER_CORE_MACROS_SVH
`define UTF8_STREAM_DECODER_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define U8D_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define U8D_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/u8d_pkg.sv
// Shared types and constants for the UTF-8 stream decoder.
// Used by the front classifier, the item queue, the back decoder and the top level.
package u8d_pkg;

  // Field widths.
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned CP_W      = 21;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned PAYLOAD_W = 7;

  // Default depth of the queue between front and back.
  localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_BAD_BYTE  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_TRUNCATED = 2'd2;

  // Byte class masks and patterns.
  localparam logic [BYTE_W-1:0] MASK_ASCII = 8'h80;
  localparam logic [BYTE_W-1:0] MASK_CONT  = 8'hC0;
  localparam logic [BYTE_W-1:0] PAT_CONT   = 8'h80;
  localparam logic [BYTE_W-1:0] MASK_LEAD2 = 8'hE0;
  localparam logic [BYTE_W-1:0] PAT_LEAD2  = 8'hC0;
  localparam logic [BYTE_W-1:0] MASK_LEAD3 = 8'hF0;
  localparam logic [BYTE_W-1:0] PAT_LEAD3  = 8'hE0;
  localparam logic [BYTE_W-1:0] MASK_LEAD4 = 8'hF8;
  localparam logic [BYTE_W-1:0] PAT_LEAD4  = 8'hF0;

  // Payload masks for each byte class.
  localparam logic [BYTE_W-1:0] PAY_LEAD2 = 8'h1F;
  localparam logic [BYTE_W-1:0] PAY_LEAD3 = 8'h0F;
  localparam logic [BYTE_W-1:0] PAY_LEAD4 = 8'h07;
  localparam logic [BYTE_W-1:0] PAY_CONT  = 8'h3F;

  // Class of one input byte as seen by the front.
  typedef enum logic [2:0] {
    CLS_ASCII,
    CLS_LEAD2,
    CLS_LEAD3,
    CLS_LEAD4,
    CLS_CONT,
    CLS_BAD
  } byte_class_t;

  // One classified item in the queue.
  typedef struct packed {
    byte_class_t          cls;
    logic [PAYLOAD_W-1:0] payload;
    logic                 last;
  } q_entry_t;

  // Queue fill status seen by the front, the back and the top level.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Back decoder sequence state.
  typedef enum logic {
    BK_IDLE,
    BK_SEQ
  } bk_state_t;

endpackage

FILE: rtl/utf8_stream_decoder_core.sv
// UTF-8 stream decoder: takes one byte per item and gives one result item per
// completed code point, unexpected byte, or sequence cut off by end_of_stream.
// A byte is accepted every cycle while the queue of QUEUE_DEPTH items between
// the classifier front and the decoding back has room; the back drains one item
// per cycle while its output register is free or being taken. After its final byte
// is accepted, a result passes through the queue and then the output register.
// code_point is zero in every result whose status is not 0.
// Depends on u8d_pkg, u8d_front, u8d_queue, u8d_back and the assertion macros.
`include "utf8_stream_decoder_core_macros.svh"

module utf8_stream_decoder_core import u8d_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [BYTE_W-1:0]   data_byte,
  input  logic                end_of_stream,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [CP_W-1:0]     code_point,
  output logic [STATUS_W-1:0] status
);

  q_status_t q_status;
  q_entry_t  push_entry;
  q_entry_t  pop_entry;
  logic      push;
  logic      pop;

  // Classify incoming bytes.
  u8d_front u_front (
    .in_valid      (in_valid),
    .data_byte     (data_byte),
    .end_of_stream (end_of_stream),
    .q_status      (q_status),
    .in_stall      (in_stall),
    .push          (push),
    .entry         (push_entry)
  );

  // Decouple front and back.
  u8d_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .status     (q_status)
  );

  // Decode sequences and hold results.
  u8d_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_status   (q_status),
    .entry      (pop_entry),
    .pop        (pop),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .code_point (code_point),
    .status     (status)
  );

  // Error results never carry a code point.
  `U8D_ASSERT_IMPL(a_err_cp_zero, clk, rst, out_valid && (status != STATUS_OK), code_point == '0, "error result carries a code point")
  // Only the three defined status codes are produced.
  `U8D_ASSERT_IMPL(a_status_legal, clk, rst, out_valid, (status == STATUS_OK) || (status == STATUS_BAD_BYTE) || (status == STATUS_TRUNCATED), "undefined status code")
  // An item accepted into an empty queue is there in the next cycle.
  `U8D_ASSERT_NEXT(a_push_visible, clk, rst, in_valid && !in_stall && q_status.empty, !q_status.empty, "accepted item missing from queue")
  // The back never takes from an empty queue or into a blocked output.
  `U8D_ASSERT_IMPL(a_pop_legal, clk, rst, pop, !q_status.empty && !(out_valid && out_stall), "illegal queue pop")

endmodule

FILE: rtl/u8d_front.sv
// Front stage: accepts input bytes and classifies them into queue items.
// Depends on u8d_pkg for the byte class encoding and the queue entry type.
module u8d_front import u8d_pkg::*; (
  input  logic              in_valid,
  input  logic [BYTE_W-1:0] data_byte,
  input  logic              end_of_stream,
  input  q_status_t         q_status,
  output logic              in_stall,
  output logic              push,
  output q_entry_t          entry
);

  // Hold the input while the queue has no room.
  assign in_stall = q_status.full;
  assign push     = in_valid && !q_status.full;

  // Sort the byte into its class and keep only its payload bits.
  always_comb begin
    entry.last = end_of_stream;
    if ((data_byte & MASK_ASCII) == 8'h00) begin
      entry.cls     = CLS_ASCII;
      entry.payload = data_byte[PAYLOAD_W-1:0];
    end else if ((data_byte & MASK_CONT) == PAT_CONT) begin
      entry.cls     = CLS_CONT;
      entry.payload = PAYLOAD_W'(data_byte & PAY_CONT);
    end else if ((data_byte & MASK_LEAD2) == PAT_LEAD2) begin
      entry.cls     = CLS_LEAD2;
      entry.payload = PAYLOAD_W'(data_byte & PAY_LEAD2);
    end else if ((data_byte & MASK_LEAD3) == PAT_LEAD3) begin
      entry.cls     = CLS_LEAD3;
      entry.payload = PAYLOAD_W'(data_byte & PAY_LEAD3);
    end else if ((data_byte & MASK_LEAD4) == PAT_LEAD4) begin
      entry.cls     = CLS_LEAD4;
      entry.payload = PAYLOAD_W'(data_byte & PAY_LEAD4);
    end else begin
      entry.cls     = CLS_BAD;
      entry.payload = '0;
    end
  end

endmodule

FILE: rtl/u8d_queue.sv
// Short FIFO of classified items between the front and the back.
// Depends on u8d_pkg for the entry and status types.
module u8d_queue import u8d_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  q_entry_t  push_entry,
  input  logic      pop,
  output q_entry_t  pop_entry,
  output q_status_t status
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  q_entry_t         mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign status.full  = (count == FULL_CNT);
  assign status.empty = (count == '0);
  assign pop_entry    = mem[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : PTR_W'(wr_ptr + 1'b1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : PTR_W'(rd_ptr + 1'b1);
      end
      if (push && !pop) begin
        count <= CNT_W'(count + 1'b1);
      end else if (pop && !push) begin
        count <= CNT_W'(count - 1'b1);
      end
    end
  end

endmodule

FILE: rtl/u8d_back.sv
// Back stage: runs the sequence state machine on queued items and registers results.
// Depends on u8d_pkg for the item, class, state and status definitions.
module u8d_back import u8d_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  q_status_t           q_status,
  input  q_entry_t            entry,
  output logic                pop,
  input  logic                out_stall,
  output logic                out_valid,
  output logic [CP_W-1:0]     code_point,
  output logic [STATUS_W-1:0] status
);

  bk_state_t           state;
  bk_state_t           state_next;
  logic [2:0]          expected_length;
  logic [2:0]          expected_length_next;
  logic [2:0]          bytes_seen;
  logic [2:0]          bytes_seen_next;
  logic [CP_W-1:0]     accumulator;
  logic [CP_W-1:0]     accumulator_next;
  logic                out_valid_next;

  logic                emit;
  logic [CP_W-1:0]     emit_cp;
  logic [STATUS_W-1:0] emit_status;
  logic [CP_W-1:0]     acc_merged;
  logic [2:0]          seen_inc;
  logic                is_lead;
  logic [2:0]          lead_length;
  logic                seq_done;

  // Take an item whenever the output register is free or being drained.
  assign pop = !q_status.empty && (!out_valid || !out_stall);

  // Shared datapath terms.
  assign acc_merged = accumulator | {{(CP_W-6){1'b0}}, entry.payload[5:0]};
  assign seen_inc   = 3'(bytes_seen + 3'd1);
  assign seq_done   = (seen_inc >= expected_length);
  assign is_lead    = (entry.cls == CLS_LEAD2) || (entry.cls == CLS_LEAD3) ||
                      (entry.cls == CLS_LEAD4);

  always_comb begin
    unique case (entry.cls)
      CLS_LEAD2: lead_length = 3'd2;
      CLS_LEAD3: lead_length = 3'd3;
      CLS_LEAD4: lead_length = 3'd4;
      default:   lead_length = 3'd0;
    endcase
  end

  // Next state and sequence registers.
  always_comb begin
    state_next           = state;
    expected_length_next = expected_length;
    bytes_seen_next      = bytes_seen;
    accumulator_next     = accumulator;
    if (pop) begin
      unique case (state)
        BK_IDLE: begin
          if (is_lead && !entry.last) begin
            state_next           = BK_SEQ;
            expected_length_next = lead_length;
            bytes_seen_next      = 3'd1;
            accumulator_next     = {{(CP_W-PAYLOAD_W-6){1'b0}}, entry.payload, 6'b0};
          end else begin
            state_next           = BK_IDLE;
            expected_length_next = '0;
            bytes_seen_next      = '0;
            accumulator_next     = '0;
          end
        end
        BK_SEQ: begin
          if (entry.cls == CLS_CONT && !seq_done && !entry.last) begin
            bytes_seen_next  = seen_inc;
            accumulator_next = {acc_merged[CP_W-7:0], 6'b0};
          end else begin
            state_next           = BK_IDLE;
            expected_length_next = '0;
            bytes_seen_next      = '0;
            accumulator_next     = '0;
          end
        end
        default: state_next = BK_IDLE;
      endcase
    end
  end

  // Result produced by the item being taken.
  always_comb begin
    emit        = 1'b0;
    emit_cp     = '0;
    emit_status = STATUS_OK;
    unique case (state)
      BK_IDLE: begin
        if (entry.cls == CLS_ASCII) begin
          emit    = 1'b1;
          emit_cp = {{(CP_W-PAYLOAD_W){1'b0}}, entry.payload};
        end else if (is_lead) begin
          emit        = entry.last;
          emit_status = STATUS_TRUNCATED;
        end else begin
          emit        = 1'b1;
          emit_status = STATUS_BAD_BYTE;
        end
      end
      BK_SEQ: begin
        if (entry.cls != CLS_CONT) begin
          emit        = 1'b1;
          emit_status = STATUS_BAD_BYTE;
        end else if (seq_done) begin
          emit    = 1'b1;
          emit_cp = acc_merged;
        end else begin
          emit        = entry.last;
          emit_status = STATUS_TRUNCATED;
        end
      end
      default: emit = 1'b0;
    endcase
  end

  // Output register holds a result until it is taken.
  assign out_valid_next = pop ? emit : (out_valid && out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= BK_IDLE;
      expected_length <= '0;
      bytes_seen      <= '0;
      accumulator     <= '0;
      out_valid       <= 1'b0;
    end else begin
      state           <= state_next;
      expected_length <= expected_length_next;
      bytes_seen      <= bytes_seen_next;
      accumulator     <= accumulator_next;
      out_valid       <= out_valid_next;
    end
  end

  // Result payload loads only with a new result.
  always_ff @(posedge clk) begin
    if (pop && emit) begin
      code_point <= emit_cp;
      status     <= emit_status;
    end
  end

endmodule

FILE: bench/tb_utf8_stream_decoder_core.sv
// Self-checking testbench for utf8_stream_decoder_core: directed and random byte
// streams, with a scoreboard that predicts each decoded result in order.
// Depends on u8d_pkg and the decoder RTL only.
module tb_utf8_stream_decoder_core import u8d_pkg::*; ();

  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES = 60;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned ITEMS_PER_PHASE = 400;

  // One expected result of the decoder.
  typedef struct packed {
    logic [CP_W-1:0]     cp;
    logic [STATUS_W-1:0] st;
  } decoded_t;

  // One byte to send.
  typedef struct packed {
    logic [BYTE_W-1:0] b;
    logic              eos;
  } stream_byte_t;

  // Predicts the decoder and checks its results against the predictions.
  class utf8_scoreboard;
    logic [2:0]      seq_len;
    logic [2:0]      seq_count;
    logic [CP_W-1:0] cp_acc;
    decoded_t        pending_q[$];
    int unsigned     bytes_in;
    int unsigned     n_ok;
    int unsigned     n_bad;
    int unsigned     n_trunc;
    int unsigned     n_errors;

    function new();
      seq_len   = '0;
      seq_count = '0;
      cp_acc    = '0;
      bytes_in  = 0;
      n_ok      = 0;
      n_bad     = 0;
      n_trunc   = 0;
      n_errors  = 0;
    endfunction

    function void go_idle();
      seq_len   = '0;
      seq_count = '0;
      cp_acc    = '0;
    endfunction

    function void expect_result(logic [CP_W-1:0] cp, logic [STATUS_W-1:0] st);
      decoded_t d;
      d.cp = cp;
      d.st = st;
      pending_q.insert(pending_q.size(), d);
    endfunction

    // Note one accepted byte and queue the result it causes, if any.
    function void note_byte(logic [BYTE_W-1:0] b, logic eos);
      logic [CP_W-1:0] bits;
      bits = '0;
      bytes_in++;
      if (seq_count == 0) begin
        if ((b & MASK_ASCII) == '0) begin
          bits[BYTE_W-1:0] = b;
          go_idle();
          expect_result(bits, STATUS_OK);
          return;
        end else if ((b & MASK_LEAD2) == PAT_LEAD2) begin
          bits[BYTE_W-1:0] = b & PAY_LEAD2;
          seq_len = 3'd2;
        end else if ((b & MASK_LEAD3) == PAT_LEAD3) begin
          bits[BYTE_W-1:0] = b & PAY_LEAD3;
          seq_len = 3'd3;
        end else if ((b & MASK_LEAD4) == PAT_LEAD4) begin
          bits[BYTE_W-1:0] = b & PAY_LEAD4;
          seq_len = 3'd4;
        end else begin
          go_idle();
          expect_result('0, STATUS_BAD_BYTE);
          return;
        end
        cp_acc    = bits << 6;
        seq_count = 3'd1;
      end else begin
        // Anything but a continuation breaks the open sequence.
        if ((b & MASK_CONT) != PAT_CONT) begin
          go_idle();
          expect_result('0, STATUS_BAD_BYTE);
          return;
        end
        bits[BYTE_W-1:0] = b & PAY_CONT;
        cp_acc    = cp_acc | bits;
        seq_count = seq_count + 3'd1;
        if (seq_count >= seq_len) begin
          bits = cp_acc;
          go_idle();
          expect_result(bits, STATUS_OK);
          return;
        end
        cp_acc = cp_acc << 6;
      end
      // End of stream with a sequence still open.
      if (eos) begin
        go_idle();
        expect_result('0, STATUS_TRUNCATED);
      end
    endfunction

    // Compare one accepted result with the oldest prediction.
    function void check_result(logic [CP_W-1:0] cp, logic [STATUS_W-1:0] st);
      decoded_t d;
      if (pending_q.size() == 0) begin
        $error("result with nothing expected: code_point %0h, status %0d", cp, st);
        n_errors++;
        return;
      end
      d = pending_q.pop_front();
      if (cp !== d.cp) begin
        $error("code_point: expected %0h, actual %0h", d.cp, cp);
        n_errors++;
      end
      if (st !== d.st) begin
        $error("status: expected %0d, actual %0d", d.st, st);
        n_errors++;
      end
      if (d.st == STATUS_OK) n_ok++;
      else if (d.st == STATUS_BAD_BYTE) n_bad++;
      else n_trunc++;
    endfunction

    function int unsigned pending();
      return pending_q.size();
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  logic [BYTE_W-1:0]   data_byte;
  logic                end_of_stream;
  logic                out_valid;
  logic                out_stall;
  logic [CP_W-1:0]     code_point;
  logic [STATUS_W-1:0] status;

  utf8_scoreboard  sb;
  stream_byte_t    stim_q[$];
  int unsigned     send_idle_pct;
  int unsigned     recv_idle_pct;
  bit              hold_request;
  int unsigned     quiet_cycles;

  utf8_stream_decoder_core uut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .data_byte     (data_byte),
    .end_of_stream (end_of_stream),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .code_point    (code_point),
    .status        (status)
  );

  always #10 clk = ~clk;

  // Queue one byte for sending.
  function void push_byte(logic [BYTE_W-1:0] b, logic eos);
    stream_byte_t s;
    s.b   = b;
    s.eos = eos;
    stim_q.insert(stim_q.size(), s);
  endfunction

  // Random lead byte of a sequence of the given length.
  function logic [BYTE_W-1:0] rand_lead(int unsigned len);
    logic [BYTE_W-1:0] r;
    r = BYTE_W'($urandom_range(255));
    case (len)
      1: rand_lead = {1'b0, r[6:0]};
      2: rand_lead = {3'b110, r[4:0]};
      3: rand_lead = {4'b1110, r[3:0]};
      default: rand_lead = {5'b11110, r[2:0]};
    endcase
  endfunction

  function logic [BYTE_W-1:0] rand_cont();
    logic [BYTE_W-1:0] r;
    r = BYTE_W'($urandom_range(255));
    return {2'b10, r[5:0]};
  endfunction

  // Mostly well-formed sequences, with raw noise, broken and cut-off sequences.
  task automatic add_random_bytes(int unsigned n);
    int unsigned start;
    int unsigned kind;
    int unsigned len;
    int unsigned conts;
    logic [BYTE_W-1:0] b;
    start = stim_q.size();
    while (stim_q.size() - start < n) begin
      kind = $urandom_range(99);
      if (kind < 75) begin
        len = $urandom_range(4, 1);
        if (len == 1) begin
          push_byte(rand_lead(1), $urandom_range(15) == 0);
        end else begin
          push_byte(rand_lead(len), 1'b0);
          for (int k = 1; k < len - 1; k++) push_byte(rand_cont(), 1'b0);
          push_byte(rand_cont(), $urandom_range(15) == 0);
        end
      end else if (kind < 85) begin
        push_byte(BYTE_W'($urandom_range(255)), $urandom_range(7) == 0);
      end else if (kind < 93) begin
        len   = $urandom_range(4, 2);
        conts = $urandom_range(len - 2);
        push_byte(rand_lead(len), 1'b0);
        for (int k = 0; k < conts; k++) push_byte(rand_cont(), 1'b0);
        do b = BYTE_W'($urandom_range(255)); while ((b & MASK_CONT) == PAT_CONT);
        push_byte(b, $urandom_range(3) == 0);
      end else begin
        len   = $urandom_range(4, 2);
        conts = $urandom_range(len - 2);
        if (conts == 0) begin
          push_byte(rand_lead(len), 1'b1);
        end else begin
          push_byte(rand_lead(len), 1'b0);
          for (int k = 1; k < conts; k++) push_byte(rand_cont(), 1'b0);
          push_byte(rand_cont(), 1'b1);
        end
      end
    end
  endtask

  // Offer one item and wait until the block takes it.
  task automatic send_item(stream_byte_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    data_byte     <= s.b;
    end_of_stream <= s.eos;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_all();
    while (stim_q.size() != 0) send_item(stim_q.pop_front());
  endtask

  // Receiver: random stall, or a long hold-off when asked.
  initial begin : receiver
    int unsigned hold_left;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Monitor both handshakes; end the run if nothing moves for too long.
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles = 0;
    end else begin
      if (out_valid && !out_stall) sb.check_result(code_point, status);
      if (in_valid && !in_stall) sb.note_byte(data_byte, end_of_stream);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("tb_utf8_stream_decoder_core: FAIL");
          $finish;
        end
      end
    end
  end

  initial begin
    sb            = new();
    rst           = 1'b1;
    in_valid      = 1'b0;
    data_byte     = '0;
    end_of_stream = 1'b0;
    hold_request  = 1'b0;
    quiet_cycles  = 0;
    send_idle_pct = 11;
    recv_idle_pct = 57;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: ASCII extremes, two-byte low, three-byte high, four-byte at both payload extremes.
    push_byte(8'h00, 1'b0);
    push_byte(8'h7F, 1'b1);
    push_byte(8'hC2, 1'b0); push_byte(8'h80, 1'b0);
    push_byte(8'hEF, 1'b0); push_byte(8'hBF, 1'b0); push_byte(8'hBF, 1'b0);
    push_byte(8'hF7, 1'b0); push_byte(8'hBF, 1'b0);
    push_byte(8'hBF, 1'b0); push_byte(8'hBF, 1'b0);
    push_byte(8'hF0, 1'b0); push_byte(8'h80, 1'b0);
    push_byte(8'h80, 1'b0); push_byte(8'h80, 1'b0);
    // A stray continuation and invalid leads while idle, the last carrying the end mark.
    push_byte(8'h80, 1'b0);
    push_byte(8'hF8, 1'b0);
    push_byte(8'hFF, 1'b1);
    // Broken sequences: ASCII and a new lead where a continuation belongs.
    push_byte(8'hC3, 1'b0); push_byte(8'h41, 1'b0);
    push_byte(8'hE2, 1'b0); push_byte(8'hC3, 1'b0);
    // Truncation on a lead and on a middle continuation.
    push_byte(8'hF4, 1'b1);
    push_byte(8'hE2, 1'b0); push_byte(8'h82, 1'b1);
    add_random_bytes(ITEMS_PER_PHASE);
    send_all();

    // Slow sender, fast receiver: the idle rates swapped.
    send_idle_pct = 57;
    recv_idle_pct = 11;
    add_random_bytes(ITEMS_PER_PHASE);
    send_all();

    // Full rate, opening with a long receiver hold-off to back up the input.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request  = 1'b1;
    add_random_bytes(ITEMS_PER_PHASE);
    send_all();
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d bytes and %0d results: %0d code points, %0d bad bytes,",
             sb.bytes_in, sb.n_ok + sb.n_bad + sb.n_trunc, sb.n_ok, sb.n_bad);
    $display("  %0d truncated sequences, %0d mismatches.", sb.n_trunc, sb.n_errors);
    if (sb.n_errors == 0 && sb.pending() == 0) begin
      $display("tb_utf8_stream_decoder_core: PASS");
    end else begin
      $display("tb_utf8_stream_decoder_core: FAIL");
    end
    $finish;
  end

endmodule
